// File: sv/mmep_pkg.sv
package mmep_pkg;

    localparam int MAX_LENGTH_BYTES = 4;

    localparam logic [7:0] MARKER = 8'hFF;
    localparam logic [7:0] TYPE_SEQ_SPECIFIC = 8'h7F;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_TYPE    = 2'd1;
    localparam logic [1:0] PH_LEN     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [1:0] KIND_STREAM = 2'd0;
    localparam logic [1:0] KIND_FIXED  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NO_MARKER   = 3'd1;
    localparam logic [2:0] ERR_BAD_LENGTH  = 3'd2;
    localparam logic [2:0] ERR_ZERO_OPAQUE = 3'd3;
    localparam logic [2:0] ERR_OVERLONG    = 3'd4;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  meta_type;
        logic [2:0]  error_code;
        logic [7:0]  data_byte;
        logic [39:0] fixed_value;
        logic [2:0]  fixed_count;
        logic [27:0] payload_length;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic       is_fixed;
        logic [2:0] need;
    } fixed_len_t;

    function automatic fixed_len_t fixed_len(input logic [7:0] t);
        fixed_len_t r;
        r.is_fixed = 1'b1;
        r.need     = 3'd0;
        case (t)
            8'h00:   r.need = 3'd2;
            8'h20:   r.need = 3'd1;
            8'h2F:   r.need = 3'd0;
            8'h51:   r.need = 3'd3;
            8'h54:   r.need = 3'd5;
            8'h58:   r.need = 3'd4;
            8'h59:   r.need = 3'd2;
            default: r.is_fixed = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/mmep_byte_if.sv
interface mmep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// File: sv/mmep_rec_if.sv
interface mmep_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  meta_type;
    logic [2:0]  error_code;
    logic [7:0]  data_byte;
    logic [39:0] fixed_value;
    logic [2:0]  fixed_count;
    logic [27:0] payload_length;
    logic        last;

    modport source (
        output valid, output record_kind, output meta_type, output error_code,
        output data_byte, output fixed_value, output fixed_count,
        output payload_length, output last, input ready
    );
    modport sink (
        input valid, input record_kind, input meta_type, input error_code,
        input data_byte, input fixed_value, input fixed_count,
        input payload_length, input last, output ready
    );
endinterface

// File: sv/midi_meta_event_parser.sv
// A result is registered in the output register and appears there in the cycle after the byte that causes it.
// Throughput: one byte per cycle; a new byte is taken while a result is held, as long as
// that result is taken in the same cycle.
// Reset (rst_n, async, active low): parser idle awaiting the 0xFF marker, all event state
// cleared, output register empty.
module midi_meta_event_parser (
    input  logic        clk,
    input  logic        rst_n,
    mmep_byte_if.sink   byte_in,
    mmep_rec_if.source  rec_out
);

    logic           step;
    logic           res_valid;
    mmep_pkg::rec_t res;
    logic           out_valid_reg;
    mmep_pkg::rec_t rec_reg;

    assign byte_in.ready = !out_valid_reg || rec_out.ready;
    assign step          = byte_in.valid && byte_in.ready;

    mmep_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .din       (byte_in.in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= res_valid;
        end
        else if (rec_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            rec_reg <= res;
        end
    end

    assign rec_out.valid          = out_valid_reg;
    assign rec_out.record_kind    = rec_reg.record_kind;
    assign rec_out.meta_type      = rec_reg.meta_type;
    assign rec_out.error_code     = rec_reg.error_code;
    assign rec_out.data_byte      = rec_reg.data_byte;
    assign rec_out.fixed_value    = rec_reg.fixed_value;
    assign rec_out.fixed_count    = rec_reg.fixed_count;
    assign rec_out.payload_length = rec_reg.payload_length;
    assign rec_out.last           = rec_reg.last;

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rec_reg.record_kind == mmep_pkg::KIND_ERROR)
        |-> rec_reg.last && (rec_reg.error_code != mmep_pkg::ERR_NONE))
        else $error("error item without last or code");

    a_fixed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rec_reg.record_kind == mmep_pkg::KIND_FIXED)
        |-> rec_reg.last && (rec_reg.error_code == mmep_pkg::ERR_NONE)
            && (rec_reg.data_byte == 8'd0) && (rec_reg.fixed_count <= 3'd5))
        else $error("malformed fixed item");

    a_stream_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (rec_reg.record_kind == mmep_pkg::KIND_STREAM)
        |-> (rec_reg.fixed_value == 40'd0) && (rec_reg.fixed_count == 3'd0)
            && (rec_reg.payload_length != 28'd0))
        else $error("malformed streamed item");

    a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rec_out.ready |=> out_valid_reg)
        else $error("held item dropped");

endmodule

// File: sv/mmep_parse.sv
module mmep_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         din,
    output logic               res_valid,
    output mmep_pkg::rec_t     res
);

    logic [1:0]  phase_reg,   phase_next;
    logic [7:0]  type_reg,    type_next;
    logic [27:0] accum_reg,   accum_next;
    logic [2:0]  seen_reg,    seen_next;
    logic [27:0] remain_reg,  remain_next;
    logic [39:0] packed_reg,  packed_next;
    logic [2:0]  count_reg,   count_next;

    mmep_pkg::fixed_len_t fl;
    logic [27:0] acc_shift;
    logic [2:0]  seen_inc;
    logic [27:0] remain_dec;
    logic [39:0] packed_shift;
    logic [2:0]  count_inc;

    assign fl           = mmep_pkg::fixed_len(type_reg);
    assign acc_shift    = {accum_reg[20:0], din[6:0]};
    assign seen_inc     = seen_reg + 3'd1;
    assign remain_dec   = (remain_reg != 28'd0) ? remain_reg - 28'd1 : 28'd0;
    assign packed_shift = {packed_reg[31:0], din};
    assign count_inc    = count_reg + 3'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        accum_next  = accum_reg;
        seen_next   = seen_reg;
        remain_next = remain_reg;
        packed_next = packed_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.meta_type = type_reg;
        case (phase_reg)
            mmep_pkg::PH_IDLE:
            begin
                if (din != mmep_pkg::MARKER)
                begin
                    res_valid       = 1'b1;
                    res.record_kind = mmep_pkg::KIND_ERROR;
                    res.meta_type   = 8'd0;
                    res.error_code  = mmep_pkg::ERR_NO_MARKER;
                    res.last        = 1'b1;
                end
                else
                begin
                    phase_next = mmep_pkg::PH_TYPE;
                end
            end
            mmep_pkg::PH_TYPE:
            begin
                type_next   = din;
                accum_next  = '0;
                seen_next   = '0;
                remain_next = '0;
                packed_next = '0;
                count_next  = '0;
                phase_next  = mmep_pkg::PH_LEN;
            end
            mmep_pkg::PH_LEN:
            begin
                res.record_kind = mmep_pkg::KIND_ERROR;
                res.last        = 1'b1;
                if (accum_reg[27:21] != 7'd0)
                begin
                    res_valid      = 1'b1;
                    res.error_code = mmep_pkg::ERR_OVERLONG;
                    phase_next     = mmep_pkg::PH_IDLE;
                end
                else
                begin
                    accum_next = acc_shift;
                    seen_next  = seen_inc;
                    if (din[7])
                    begin
                        if (({1'b0, seen_inc} >= 4'(mmep_pkg::MAX_LENGTH_BYTES))
                            || (seen_inc == 3'd0))
                        begin
                            res_valid      = 1'b1;
                            res.error_code = mmep_pkg::ERR_OVERLONG;
                            phase_next     = mmep_pkg::PH_IDLE;
                        end
                    end
                    else if (fl.is_fixed && (acc_shift != {25'd0, fl.need}))
                    begin
                        res_valid          = 1'b1;
                        res.error_code     = mmep_pkg::ERR_BAD_LENGTH;
                        res.payload_length = acc_shift;
                        phase_next         = mmep_pkg::PH_IDLE;
                    end
                    else if ((type_reg == mmep_pkg::TYPE_SEQ_SPECIFIC)
                             && (acc_shift == 28'd0))
                    begin
                        res_valid      = 1'b1;
                        res.error_code = mmep_pkg::ERR_ZERO_OPAQUE;
                        phase_next     = mmep_pkg::PH_IDLE;
                    end
                    else if (acc_shift == 28'd0)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = mmep_pkg::KIND_FIXED;
                        phase_next      = mmep_pkg::PH_IDLE;
                    end
                    else
                    begin
                        remain_next = acc_shift;
                        phase_next  = mmep_pkg::PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                remain_next        = remain_dec;
                res.payload_length = accum_reg;
                res.last           = (remain_dec == 28'd0);
                if (fl.is_fixed)
                begin
                    packed_next = packed_shift;
                    count_next  = count_inc;
                    if (remain_dec == 28'd0)
                    begin
                        res_valid       = 1'b1;
                        res.record_kind = mmep_pkg::KIND_FIXED;
                        res.fixed_value = packed_shift;
                        res.fixed_count = count_inc;
                        phase_next      = mmep_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.record_kind = mmep_pkg::KIND_STREAM;
                    res.data_byte   = din;
                    if (remain_dec == 28'd0)
                    begin
                        phase_next = mmep_pkg::PH_IDLE;
                    end
                end
            end
        endcase
        if (!step)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mmep_pkg::PH_IDLE;
            type_reg   <= '0;
            accum_reg  <= '0;
            seen_reg   <= '0;
            remain_reg <= '0;
            packed_reg <= '0;
            count_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            accum_reg  <= accum_next;
            seen_reg   <= seen_next;
            remain_reg <= remain_next;
            packed_reg <= packed_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sim/mmep_result_checker.sv
`timescale 1ns / 1ps

module mmep_result_checker (
    input  logic  clk,
    input  logic  rst_n,
    mmep_byte_if  byte_ch,
    mmep_rec_if   rec_ch,
    output int    failures,
    output int    pending
);

    localparam logic [7:0] MT_SEQ_NUMBER  = 8'h00;
    localparam logic [7:0] MT_CHAN_PREFIX = 8'h20;
    localparam logic [7:0] MT_END_TRACK   = 8'h2F;
    localparam logic [7:0] MT_TEMPO       = 8'h51;
    localparam logic [7:0] MT_SMPTE       = 8'h54;
    localparam logic [7:0] MT_TIME_SIG    = 8'h58;
    localparam logic [7:0] MT_KEY_SIG     = 8'h59;

    logic [1:0]  phase;
    logic [7:0]  cur_type;
    logic [27:0] len_acc;
    logic [2:0]  len_seen;
    logic [27:0] remaining;
    logic [39:0] packed_val;
    logic [2:0]  packed_cnt;

    mmep_pkg::rec_t expected_recs[$];

    // payload size a fixed meta type requires, -1 for streamed types
    function automatic int required_len(input logic [7:0] t);
        case (t)
            MT_SEQ_NUMBER:  return 2;
            MT_CHAN_PREFIX: return 1;
            MT_END_TRACK:   return 0;
            MT_TEMPO:       return 3;
            MT_SMPTE:       return 5;
            MT_TIME_SIG:    return 4;
            MT_KEY_SIG:     return 2;
            default:        return -1;
        endcase
    endfunction

    task automatic add_expected(input mmep_pkg::rec_t r);
        expected_recs = {expected_recs, r};
    endtask

    task automatic raise_error(input logic [7:0] t, input logic [2:0] code,
                               input logic [27:0] plen);
        mmep_pkg::rec_t r;
        r = '0;
        r.record_kind    = mmep_pkg::KIND_ERROR;
        r.meta_type      = t;
        r.error_code     = code;
        r.payload_length = plen;
        r.last           = 1'b1;
        add_expected(r);
        phase = mmep_pkg::PH_IDLE;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        mmep_pkg::rec_t r;
        int   need;
        r = '0;
        case (phase)
            mmep_pkg::PH_IDLE:
            begin
                if (b != mmep_pkg::MARKER)
                    raise_error(8'h00, mmep_pkg::ERR_NO_MARKER, 28'd0);
                else
                    phase = mmep_pkg::PH_TYPE;
            end
            mmep_pkg::PH_TYPE:
            begin
                cur_type   = b;
                len_acc    = '0;
                len_seen   = '0;
                remaining  = '0;
                packed_val = '0;
                packed_cnt = '0;
                phase      = mmep_pkg::PH_LEN;
            end
            mmep_pkg::PH_LEN:
            begin
                if (len_acc[27:21] != 0)
                    raise_error(cur_type, mmep_pkg::ERR_OVERLONG, 28'd0);
                else
                begin
                    len_acc  = {len_acc[20:0], b[6:0]};
                    len_seen = len_seen + 3'd1;
                    if (b[7])
                    begin
                        if (len_seen >= mmep_pkg::MAX_LENGTH_BYTES || len_seen == 0)
                            raise_error(cur_type, mmep_pkg::ERR_OVERLONG, 28'd0);
                    end
                    else
                    begin
                        need = required_len(cur_type);
                        if (need >= 0 && len_acc != need)
                            raise_error(cur_type, mmep_pkg::ERR_BAD_LENGTH, len_acc);
                        else if (cur_type == mmep_pkg::TYPE_SEQ_SPECIFIC && len_acc == 0)
                            raise_error(cur_type, mmep_pkg::ERR_ZERO_OPAQUE, 28'd0);
                        else if (len_acc == 0)
                        begin
                            r.record_kind = mmep_pkg::KIND_FIXED;
                            r.meta_type   = cur_type;
                            r.last        = 1'b1;
                            add_expected(r);
                            phase = mmep_pkg::PH_IDLE;
                        end
                        else
                        begin
                            remaining = len_acc;
                            phase     = mmep_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            default:
            begin
                if (remaining != 0)
                    remaining = remaining - 28'd1;
                r.meta_type      = cur_type;
                r.payload_length = len_acc;
                if (required_len(cur_type) >= 0)
                begin
                    packed_val = {packed_val[31:0], b};
                    packed_cnt = packed_cnt + 3'd1;
                    if (remaining == 0)
                    begin
                        r.record_kind = mmep_pkg::KIND_FIXED;
                        r.fixed_value = packed_val;
                        r.fixed_count = packed_cnt;
                        r.last        = 1'b1;
                        add_expected(r);
                        phase = mmep_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    r.record_kind = mmep_pkg::KIND_STREAM;
                    r.data_byte   = b;
                    r.last        = (remaining == 0);
                    add_expected(r);
                    if (remaining == 0)
                        phase = mmep_pkg::PH_IDLE;
                end
            end
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [39:0] exp_v,
                             input logic [39:0] act_v);
        if (act_v !== exp_v)
        begin
            failures++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_record();
        mmep_pkg::rec_t e;
        if (expected_recs.size() == 0)
        begin
            failures++;
            $display("%0t: item with nothing expected, expected none got kind %0h type %0h",
                     $time, rec_ch.record_kind, rec_ch.meta_type);
        end
        else
        begin
            e = expected_recs.pop_front();
            cmp_field("record_kind", 40'(e.record_kind), 40'(rec_ch.record_kind));
            cmp_field("meta_type", 40'(e.meta_type), 40'(rec_ch.meta_type));
            cmp_field("error_code", 40'(e.error_code), 40'(rec_ch.error_code));
            cmp_field("data_byte", 40'(e.data_byte), 40'(rec_ch.data_byte));
            cmp_field("fixed_value", e.fixed_value, rec_ch.fixed_value);
            cmp_field("fixed_count", 40'(e.fixed_count), 40'(rec_ch.fixed_count));
            cmp_field("payload_length", 40'(e.payload_length),
                      40'(rec_ch.payload_length));
            cmp_field("last", 40'(e.last), 40'(rec_ch.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase      = mmep_pkg::PH_IDLE;
            cur_type   = '0;
            len_acc    = '0;
            len_seen   = '0;
            remaining  = '0;
            packed_val = '0;
            packed_cnt = '0;
            failures   = 0;
            expected_recs.delete();
            pending <= 0;
        end
        else
        begin
            if (rec_ch.valid && rec_ch.ready)
                check_record();
            if (byte_ch.valid && byte_ch.ready)
                parse_byte(byte_ch.in_byte);
            pending <= expected_recs.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_BYTES = 1000;

    // fixed meta types and their payload sizes
    localparam logic [7:0] FIXED_TYPES [7] = '{8'h00, 8'h20, 8'h2F, 8'h51, 8'h54, 8'h58, 8'h59};
    localparam int         FIXED_NEED  [7] = '{2, 1, 0, 3, 5, 4, 2};
    localparam logic [7:0] MT_END_TRACK = 8'h2F;
    localparam logic [7:0] MT_SMPTE     = 8'h54;
    localparam logic [7:0] MT_CHAN_PREFIX = 8'h20;
    localparam logic [7:0] MT_TEXT      = 8'h01;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   bytes_sent;
    bit   no_gaps;

    mmep_byte_if byte_ch ();
    mmep_rec_if  rec_ch ();

    midi_meta_event_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch.sink),
        .rec_out (rec_ch.source)
    );

    mmep_result_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .rec_ch   (rec_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // variable-length length, optionally padded with leading zero groups
    task automatic send_len(input logic [27:0] v, input int pad);
        int          nb;
        logic [27:0] sh;
        nb = 1;
        while (nb < 4 && (v >> (7 * nb)) != 0)
            nb++;
        nb = nb + pad;
        if (nb > 4)
            nb = 4;
        for (int i = nb - 1; i >= 0; i--)
        begin
            sh = v >> (7 * i);
            send_byte({(i != 0), sh[6:0]});
        end
    endtask

    function automatic logic [7:0] stream_type();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(1, 7));
            1:       return 8'($urandom_range(8'h08, 8'h1F));
            2:       return 8'($urandom_range(8'h60, 8'h7E));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    task automatic send_payload(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_event();
        int          kind;
        int          k;
        int          n;
        int          nb;
        logic [27:0] v;
        kind    = $urandom_range(0, 99);
        k       = $urandom_range(0, 6);
        no_gaps = ($urandom_range(0, 4) == 0);
        if (kind < 8)
            send_byte(8'($urandom_range(0, 254)));
        else if (kind < 38)
        begin
            send_byte(mmep_pkg::MARKER);
            send_byte(FIXED_TYPES[k]);
            send_len(28'(FIXED_NEED[k]),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
            send_payload(FIXED_NEED[k]);
        end
        else if (kind < 70)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            send_byte(mmep_pkg::MARKER);
            send_byte(kind < 63 ? stream_type() : mmep_pkg::TYPE_SEQ_SPECIFIC);
            send_len(28'(n), ($urandom_range(0, 5) == 0) ? 1 : 0);
            send_payload(n);
        end
        else if (kind < 73)
        begin
            send_byte(mmep_pkg::MARKER);
            send_byte(mmep_pkg::TYPE_SEQ_SPECIFIC);
            send_len(28'd0, $urandom_range(0, 3));
        end
        else if (kind < 83)
        begin
            nb = $urandom_range(1, 4);
            v  = 28'($urandom() & ((28'd1 << (7 * nb)) - 28'd1));
            if (v == FIXED_NEED[k])
                v = v + 28'd1;
            send_byte(mmep_pkg::MARKER);
            send_byte(FIXED_TYPES[k]);
            send_len(v, 0);
        end
        else if (kind < 88)
        begin
            send_byte(mmep_pkg::MARKER);
            send_byte(8'($urandom_range(0, 255)));
            repeat (4) send_byte({1'b1, 7'($urandom_range(0, 127))});
        end
        else if (kind < 93)
        begin
            send_byte(mmep_pkg::MARKER);
            send_byte($urandom_range(0, 1) ? MT_END_TRACK : stream_type());
            send_len(28'd0, $urandom_range(0, 3));
        end
        else
        begin
            // cut-off event: the next event's first byte lands in the length field
            send_byte(mmep_pkg::MARKER);
            send_byte(FIXED_TYPES[k]);
            repeat ($urandom_range(0, 2)) send_byte(8'h80);
        end
    endtask

    // sink side: ready in runs, with random stalls
    initial
    begin
        rec_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            rec_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (gap_len() > 0)
            begin
                rec_ch.ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [7:0] directed_bytes [31];
        directed_bytes = '{
            8'h00,
            mmep_pkg::MARKER, MT_END_TRACK, 8'h00,
            mmep_pkg::MARKER, MT_SMPTE, 8'h05, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01,
            mmep_pkg::MARKER, mmep_pkg::TYPE_SEQ_SPECIFIC, 8'h00,
            mmep_pkg::MARKER, MT_CHAN_PREFIX, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
            mmep_pkg::MARKER, MT_TEXT, 8'h80, 8'h80, 8'h80, 8'h80,
            mmep_pkg::MARKER, 8'hFF, 8'h01, 8'h5A
        };
        bytes_sent = 0;
        no_gaps    = 1'b0;
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        while (bytes_sent < NUM_BYTES)
            send_event();
        byte_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
